// ----- rtl/gva_pkg.sv -----
// shared types and constants of the gravity velocity accumulator
`default_nettype none

package gva_pkg;

  // fractional bits of positions and masses
  localparam int POS_FRAC_BITS = 8;

  // item actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_NEIGH = 2'd2;
  localparam logic [1:0] ACT_END   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_MASS = 2'd0;
  localparam logic [1:0] REG_VEL_X    = 2'd1;
  localparam logic [1:0] REG_VEL_Y    = 2'd2;
  localparam logic [1:0] REG_VEL_Z    = 2'd3;

  // gravitational constant, round(0.06111 * 2^32)
  localparam logic [27:0] G_Q32 = 28'd262465451;

  // divide by ten as multiply by ceil(2^42 / 10) then shift right by 42,
  // exact for magnitudes up to 2^39
  localparam logic [38:0] DIV10_M  = 39'd439804651111;
  localparam int          DIV10_SH = 42;

  // bound on own coordinates, 40000 units in position format
  localparam logic [32:0] BOUND_LIM = 33'(64'd40000 << POS_FRAC_BITS);

  // per-axis contribution cap and velocity limits
  localparam logic [40:0] CAP40   = 41'h100_0000_0000;
  localparam logic [39:0] VEL_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] VEL_MIN = 40'h80_0000_0000;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        body_mass;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [31:0]        own_mass;
    logic signed [39:0] init_vel_x;
    logic signed [39:0] init_vel_y;
    logic signed [39:0] init_vel_z;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [39:0] vel_x;
    logic signed [39:0] vel_y;
    logic signed [39:0] vel_z;
    logic               out_of_bounds;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/gva_in_if.sv -----
// input item channel
`default_nettype none

interface gva_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0]        body_mass;

  modport source (output valid, action, pos_x, pos_y, pos_z, body_mass, input ready);
  modport sink (input valid, action, pos_x, pos_y, pos_z, body_mass, output ready);
endinterface

`default_nettype wire

// ----- rtl/gva_out_if.sv -----
// result item channel
`default_nettype none

interface gva_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] vel_x;
  logic signed [39:0] vel_y;
  logic signed [39:0] vel_z;
  logic               out_of_bounds;

  modport source (output valid, vel_x, vel_y, vel_z, out_of_bounds, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, out_of_bounds, output ready);
endinterface

`default_nettype wire

// ----- rtl/gva_cfg_if.sv -----
// configuration write channel
`default_nettype none

interface gva_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [39:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/gva_front.sv -----
// front end: accepts items and queues them for the engine
`default_nettype none

module gva_front import gva_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  gva_in_if.sink    item,
  output head_t     head,
  input  logic      pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              fifo [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               take;

  assign item.ready = (count != CNT_W'(DEPTH));
  assign push       = item.valid && item.ready;
  assign take       = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{action: item.action, pos_x: item.pos_x, pos_y: item.pos_y,
                        pos_z: item.pos_z, body_mass: item.body_mass};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gva_back.sv -----
// back end: sequential engine for start, frame and neighbour items
`default_nettype none

module gva_back import gva_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  head_t     head,
  output logic      pop,
  input  cfg_regs_t cfgr,
  output logic      res_valid,
  input  logic      res_ready,
  output result_t   res
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIFF  = 4'd1;
  localparam logic [3:0] ST_MAX   = 4'd2;
  localparam logic [3:0] ST_NORM  = 4'd3;
  localparam logic [3:0] ST_SCALE = 4'd4;
  localparam logic [3:0] ST_MR2   = 4'd5;
  localparam logic [3:0] ST_SQRT  = 4'd6;
  localparam logic [3:0] ST_MDEN  = 4'd7;
  localparam logic [3:0] ST_MNUM  = 4'd8;
  localparam logic [3:0] ST_DSET  = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_ACC   = 4'd11;
  localparam logic [3:0] ST_SLOAD = 4'd12;

  logic [3:0]         state;
  logic signed [39:0] vel [3];
  logic signed [31:0] own [3];
  logic signed [31:0] cur_pos [3];
  logic [31:0]        cur_mass;
  logic [32:0]        mag [3];
  logic [2:0]         neg;
  logic [32:0]        mx;
  logic signed [5:0]  sh;
  logic [19:0]        magn [3];
  logic [2:0]         step;
  logic [63:0]        prod;
  logic [31:0]        mm_hi;
  logic [91:0]        gm;
  logic [41:0]        r2;
  logic [41:0]        sq_v;
  logic [42:0]        sq_r;
  logic [41:0]        sq_bit;
  logic [62:0]        den;
  logic [111:0]       num;
  logic [127:0]       rem;
  logic [147:0]       dsh;
  logic [43:0]        quot;
  logic [5:0]         dcnt;
  logic               sat;
  logic [1:0]         axis;
  logic               start_mode;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic               out_free;
  logic [32:0]        abs_own [3];
  logic               oob;
  logic signed [32:0] diff [3];
  logic [32:0]        m01;
  logic signed [6:0]  e_val;
  logic [133:0]       wide_num;
  logic [42:0]        sq_t;
  logic [40:0]        cval;
  logic signed [41:0] addend;
  logic signed [41:0] vsum;
  logic signed [39:0] iv_sel;
  logic [39:0]        iv_abs;

  // shared 32x32 multiplier, operands chosen by state and step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MR2: begin
        case (step)
          3'd0: begin mul_a = 32'(magn[0]); mul_b = 32'(magn[0]); end
          3'd1: begin mul_a = 32'(magn[1]); mul_b = 32'(magn[1]); end
          3'd2: begin mul_a = 32'(magn[2]); mul_b = 32'(magn[2]); end
          3'd3: begin mul_a = cfgr.own_mass; mul_b = cur_mass; end
          3'd4: begin mul_a = prod[31:0]; mul_b = 32'(G_Q32); end
          3'd5: begin mul_a = mm_hi; mul_b = 32'(G_Q32); end
          default: ;
        endcase
      end
      ST_MDEN: begin
        case (step)
          3'd0: begin mul_a = r2[31:0]; mul_b = 32'(sq_r[20:0]); end
          3'd1: begin mul_a = 32'(r2[41:32]); mul_b = 32'(sq_r[20:0]); end
          default: ;
        endcase
      end
      ST_MNUM: begin
        case (step)
          3'd0: begin mul_a = gm[31:0]; mul_b = 32'(magn[axis]); end
          3'd1: begin mul_a = gm[63:32]; mul_b = 32'(magn[axis]); end
          3'd2: begin mul_a = 32'(gm[91:64]); mul_b = 32'(magn[axis]); end
          default: ;
        endcase
      end
      // reciprocal of ten, four partial products
      ST_SLOAD: begin
        case (step)
          3'd0: begin mul_a = iv_abs[31:0]; mul_b = DIV10_M[31:0]; end
          3'd1: begin mul_a = iv_abs[31:0]; mul_b = 32'(DIV10_M[38:32]); end
          3'd2: begin mul_a = 32'(iv_abs[39:32]); mul_b = DIV10_M[31:0]; end
          3'd3: begin mul_a = 32'(iv_abs[39:32]); mul_b = 32'(DIV10_M[38:32]); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_own[i] = own[i][31] ? 33'(-34'(own[i])) : 33'(own[i]);
      diff[i]    = 33'(cur_pos[i]) - 33'(own[i]);
    end
    oob = (abs_own[0] > BOUND_LIM) || (abs_own[1] > BOUND_LIM) || (abs_own[2] > BOUND_LIM);
  end

  assign out_free = !res_valid || res_ready;

  always_comb begin
    pop = 1'b0;
    if (state == ST_IDLE && head.valid) begin
      pop = (head.item.action != ACT_END) || out_free;
    end
  end

  assign m01      = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign e_val    = 7'sd16 + $signed({sh, 1'b0});
  assign wide_num = {22'd0, num} << 6'(-e_val);
  assign sq_t     = sq_r + 43'(sq_bit);
  assign cval     = (sat || quot > 44'(CAP40)) ? CAP40 : quot[40:0];
  assign addend   = neg[axis] ? -$signed({1'b0, cval}) : $signed({1'b0, cval});
  assign vsum     = $signed({{2{vel[axis][39]}}, vel[axis]}) + addend;

  always_comb begin
    case (axis)
      2'd0:    iv_sel = cfgr.init_vel_x;
      2'd1:    iv_sel = cfgr.init_vel_y;
      default: iv_sel = cfgr.init_vel_z;
    endcase
  end

  assign iv_abs = iv_sel[39] ? 40'(-iv_sel) : 40'(iv_sel);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      res_valid  <= 1'b0;
      start_mode <= 1'b0;
      axis       <= '0;
      step       <= '0;
      for (int i = 0; i < 3; i++) begin
        vel[i] <= '0;
        own[i] <= '0;
      end
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (head.item.action)
              ACT_START: begin
                start_mode <= 1'b1;
                axis       <= '0;
                step       <= '0;
                state      <= ST_SLOAD;
              end
              ACT_BEGIN: begin
                own[0] <= head.item.pos_x;
                own[1] <= head.item.pos_y;
                own[2] <= head.item.pos_z;
              end
              ACT_NEIGH: begin
                cur_pos[0] <= head.item.pos_x;
                cur_pos[1] <= head.item.pos_y;
                cur_pos[2] <= head.item.pos_z;
                cur_mass   <= head.item.body_mass;
                start_mode <= 1'b0;
                state      <= ST_DIFF;
              end
              ACT_END: begin
                res_valid         <= 1'b1;
                res.vel_x         <= vel[0];
                res.vel_y         <= vel[1];
                res.vel_z         <= vel[2];
                res.out_of_bounds <= oob;
              end
              default: ;
            endcase
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= diff[i][32];
            mag[i] <= diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
          end
          state <= ST_MAX;
        end
        ST_MAX: begin
          mx    <= (m01 > mag[2]) ? m01 : mag[2];
          sh    <= '0;
          state <= (m01 == '0 && mag[2] == '0) ? ST_IDLE : ST_NORM;
        end
        ST_NORM: begin
          if (mx[32:20] != '0) begin
            mx <= mx >> 1;
            sh <= sh + 6'sd1;
          end else if (!mx[19]) begin
            mx <= mx << 1;
            sh <= sh - 6'sd1;
          end else begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          for (int i = 0; i < 3; i++) begin
            magn[i] <= (sh > 0) ? 20'(mag[i] >> sh) : 20'(mag[i] << 6'(-sh));
          end
          step  <= '0;
          state <= ST_MR2;
        end
        ST_MR2: begin
          step <= step + 1'b1;
          case (step)
            3'd1: r2 <= prod[41:0];
            3'd2, 3'd3: r2 <= r2 + prod[41:0];
            3'd4: mm_hi <= prod[63:32];
            3'd5: gm <= 92'(prod);
            3'd6: begin
              gm     <= gm + {prod[59:0], 32'd0};
              sq_v   <= r2;
              sq_r   <= '0;
              sq_bit <= 42'd1 << 40;
              state  <= ST_SQRT;
            end
            default: ;
          endcase
        end
        ST_SQRT: begin
          if (43'(sq_v) >= sq_t) begin
            sq_v <= sq_v - sq_t[41:0];
            sq_r <= (sq_r >> 1) + 43'(sq_bit);
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            step  <= '0;
            state <= ST_MDEN;
          end
        end
        ST_MDEN: begin
          step <= step + 1'b1;
          case (step)
            3'd1: den <= 63'(prod);
            3'd2: begin
              den   <= den + {prod[30:0], 32'd0};
              axis  <= '0;
              step  <= '0;
              state <= ST_MNUM;
            end
            default: ;
          endcase
        end
        ST_MNUM: begin
          step <= step + 1'b1;
          case (step)
            3'd1: num <= 112'(prod);
            3'd2: num <= num + (112'(prod) << 32);
            3'd3: begin
              num   <= num + (112'(prod) << 64);
              state <= ST_DSET;
            end
            default: ;
          endcase
        end
        ST_DSET: begin
          if (e_val < 0) begin
            sat <= |wide_num[133:128];
            rem <= wide_num[127:0];
            dsh <= {42'd0, den, 43'd0};
          end else begin
            sat <= 1'b0;
            rem <= {16'd0, num};
            dsh <= {(105'(den) << e_val[5:0]), 43'd0};
          end
          quot  <= '0;
          dcnt  <= 6'd43;
          state <= ST_DIV;
        end
        // magnitude of the initial velocity times the reciprocal of ten
        ST_SLOAD: begin
          neg[axis] <= iv_sel[39];
          step      <= step + 1'b1;
          case (step)
            3'd1: num <= 112'(prod);
            3'd2, 3'd3: num <= num + (112'(prod) << 32);
            3'd4: begin
              quot  <= 44'((num + (112'(prod) << 64)) >> DIV10_SH);
              state <= ST_ACC;
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if ({20'd0, rem} >= dsh) begin
            rem  <= rem - dsh[127:0];
            quot <= {quot[42:0], 1'b1};
          end else begin
            quot <= {quot[42:0], 1'b0};
          end
          dsh <= dsh >> 1;
          if (dcnt == '0) begin
            state <= ST_ACC;
          end else begin
            dcnt <= dcnt - 1'b1;
          end
        end
        ST_ACC: begin
          if (start_mode) begin
            vel[axis] <= neg[axis] ? -$signed(quot[39:0]) : $signed(quot[39:0]);
          end else if (vsum > $signed({2'b00, VEL_MAX})) begin
            vel[axis] <= VEL_MAX;
          end else if (vsum < $signed({2'b11, VEL_MIN})) begin
            vel[axis] <= VEL_MIN;
          end else begin
            vel[axis] <= vsum[39:0];
          end
          step <= '0;
          if (axis == 2'd2) begin
            state <= ST_IDLE;
          end else begin
            axis  <= axis + 1'b1;
            state <= start_mode ? ST_SLOAD : ST_MNUM;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gravity_velocity_accumulator_unit.sv -----
// top level of the gravity velocity accumulator
//
// channels: item takes one action per item (start, frame begin, neighbour,
// frame end) with a position and a neighbour mass; result gives the velocity
// and an out-of-bounds flag, one item per frame end; cfg writes own mass and
// the initial velocity, always ready, to be used only while the block is idle
// items go into a short queue (QUEUE_DEPTH entries) and an engine behind it
// works on them one at a time, so item stays ready while the engine is busy as long as the queue has room
// steps per item: frame begin and frame end are handled in the idle state;
// start takes per axis four partial products of a reciprocal multiply, then
// a store; neighbour normalises, takes a bit-serial square root, then per
// axis multiplies and runs a bit-serial restoring divider (44-bit quotient)
// a frame end item leaves the queue head only when result is free and is
// registered into result, valid in the next cycle
// when result is stalled a frame end item waits at the queue head, later items
// keep filling the queue, and item drops ready once the queue is full
// reset clears the velocity, own position, configuration and the queue
`default_nettype none

module gravity_velocity_accumulator_unit import gva_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  gva_in_if.sink     item,
  gva_out_if.source  result,
  gva_cfg_if.sink    cfg
);

  head_t     head;
  logic      pop;
  cfg_regs_t cfgr;
  result_t   res;
  logic      res_valid;

  // configuration registers, with cfg always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfgr <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OWN_MASS: cfgr.own_mass   <= cfg.data[31:0];
        REG_VEL_X:    cfgr.init_vel_x <= cfg.data;
        REG_VEL_Y:    cfgr.init_vel_y <= cfg.data;
        REG_VEL_Z:    cfgr.init_vel_z <= cfg.data;
        default: ;
      endcase
    end
  end

  // front: item queue
  gva_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .head (head),
    .pop  (pop)
  );

  // back: arithmetic engine with the result register
  gva_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfgr      (cfgr),
    .res_valid (res_valid),
    .res_ready (result.ready),
    .res       (res)
  );

  assign result.valid         = res_valid;
  assign result.vel_x         = res.vel_x;
  assign result.vel_y         = res.vel_y;
  assign result.vel_z         = res.vel_z;
  assign result.out_of_bounds = res.out_of_bounds;

endmodule

`default_nettype wire

// ----- rtl/gva_checker.sv -----
// port checks of the gravity velocity accumulator and their binding
`default_nettype none

module gva_checker (
  input wire               clk,
  input wire               rst,
  input wire               item_ready,
  input wire               res_valid,
  input wire               res_ready,
  input wire signed [39:0] vel_x,
  input wire signed [39:0] vel_y,
  input wire signed [39:0] vel_z,
  input wire               oob,
  input wire               cfg_ready
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(vel_x) && $stable(vel_y)
      && $stable(vel_z) && $stable(oob))
    else $error("stalled result changed");

  // no result straight after reset
  a_rst_res: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid after reset");

  // queue empty after reset
  a_rst_queue: assert property (@(posedge clk) $past(rst) |-> item_ready)
    else $error("item not ready after reset");

  // configuration never stalls
  a_cfg_ready: assert property (@(posedge clk) !rst |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind gravity_velocity_accumulator_unit gva_checker u_gva_checker (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .vel_x      (result.vel_x),
  .vel_y      (result.vel_y),
  .vel_z      (result.vel_z),
  .oob        (result.out_of_bounds),
  .cfg_ready  (cfg.ready)
);

`default_nettype wire
